/* src/vbr_pkg.sv */
package vbr_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int AXIS_COUNT     = 3;
   localparam int REQ_DATA_WIDTH = AXIS_COUNT * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = (2 * AXIS_COUNT + 1) * FIELD_WIDTH;

   localparam int STATE_WIDTH = 3;

   typedef logic [STATE_WIDTH-1:0] state_type;

   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_SQUARE = 3'd1;
   localparam state_type ST_MERGE  = 3'd2;
   localparam state_type ST_ROOT   = 3'd3;
   localparam state_type ST_SEND   = 3'd4;

endpackage

/* src/vertex_bounds_and_radius_core.sv */
// Running axis-aligned bounding box and bounding radius of a vertex stream.
// Each req transaction carries one vertex as signed Q16.16 x, y, z in tdata.
// tuser set starts a new object at that vertex; tlast set ends the object,
// and after that vertex has been merged the block sends one rsp transaction
// with the per-axis minimum and maximum and the radius, the floor square
// root of the largest squared distance from the origin, in unsigned Q16.16.
// After a vertex is accepted req_tready stays low until the block is idle
// again, so a new vertex is not taken before the last one is merged: one
// shared multiplier squares x, y and z in turn and a merge state updates
// the bounds. A last vertex then passes through the square root, which
// produces one result bit per cycle, then a send state raises rsp_tvalid.
// Reset clears the bounds and the peak square to zero, so a vertex that
// arrives without tuser after reset merges with the origin. Nothing is
// cleared by tlast. The result sits in an output register; while the
// receiver stalls, the next object's vertices are still accepted, and only
// a further result waits until that register has been taken.
module vertex_bounds_and_radius_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vertex_x, vertex_y, vertex_z
   input  logic [vbr_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // first_vertex
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // min_x, min_y, min_z, max_x, max_y, max_z, radius
   output logic [vbr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import vbr_pkg::*;

   localparam int CW         = COORD_WIDTH;
   localparam int SQ_WIDTH   = 2 * CW;
   localparam int REM_WIDTH  = CW + 2;
   localparam int STEP_WIDTH = $clog2(CW);

   localparam logic [STEP_WIDTH-1:0] STEP_X    = STEP_WIDTH'(0);
   localparam logic [STEP_WIDTH-1:0] STEP_Y    = STEP_WIDTH'(1);
   localparam logic [STEP_WIDTH-1:0] STEP_Z    = STEP_WIDTH'(2);
   localparam logic [STEP_WIDTH-1:0] STEP_SUM  = STEP_WIDTH'(3);
   localparam logic [STEP_WIDTH-1:0] STEP_ROOT = STEP_WIDTH'(CW - 1);

   state_type                  state_ff, state_in;
   logic [STEP_WIDTH-1:0]      step_ff, step_in;
   logic signed [CW-1:0]       coord_ff [AXIS_COUNT];
   logic signed [CW-1:0]       coord_in [AXIS_COUNT];
   logic                       first_ff, first_in;
   logic                       last_ff, last_in;
   logic [SQ_WIDTH-1:0]        product_ff, product_in;
   logic [SQ_WIDTH-1:0]        sum_ff, sum_in;
   logic signed [CW-1:0]       min_ff [AXIS_COUNT];
   logic signed [CW-1:0]       min_in [AXIS_COUNT];
   logic signed [CW-1:0]       max_ff [AXIS_COUNT];
   logic signed [CW-1:0]       max_in [AXIS_COUNT];
   logic [SQ_WIDTH-1:0]        peak_ff, peak_in;
   logic [SQ_WIDTH-1:0]        num_ff, num_in;
   logic [REM_WIDTH-1:0]       rem_ff, rem_in;
   logic [CW-1:0]              root_ff, root_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic signed [CW-1:0]       mult_src;
   logic [CW-1:0]              mult_mag;
   logic [REM_WIDTH-1:0]       rem_shift;
   logic [REM_WIDTH-1:0]       trial;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      unique case (step_ff)
         STEP_Y:  mult_src = coord_ff[1];
         STEP_Z:  mult_src = coord_ff[2];
         default: mult_src = coord_ff[0];
      endcase
      mult_mag  = mult_src[CW-1] ? CW'(-mult_src) : CW'(mult_src);
      rem_shift = {rem_ff[REM_WIDTH-3:0], num_ff[SQ_WIDTH-1 -: 2]};
      trial     = {root_ff, 2'b01};
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      coord_in     = coord_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      product_in   = SQ_WIDTH'(mult_mag) * SQ_WIDTH'(mult_mag);
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      peak_in      = peak_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  coord_in[i] = signed'(req_tdata[i*FIELD_WIDTH +: CW]);
               end
               first_in = req_tuser;
               last_in  = req_tlast;
               sum_in   = '0;
               step_in  = STEP_X;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (step_ff != STEP_X) begin
               sum_in = sum_ff + product_ff;
            end
            if (step_ff == STEP_SUM) begin
               state_in = ST_MERGE;
            end else begin
               step_in = step_ff + STEP_WIDTH'(1);
            end
         end
         ST_MERGE: begin
            if (first_ff) begin
               min_in  = coord_ff;
               max_in  = coord_ff;
               peak_in = sum_ff;
            end else begin
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  if (coord_ff[i] < min_ff[i]) begin
                     min_in[i] = coord_ff[i];
                  end
                  if (coord_ff[i] > max_ff[i]) begin
                     max_in[i] = coord_ff[i];
                  end
               end
               if (sum_ff > peak_ff) begin
                  peak_in = sum_ff;
               end
            end
            if (last_ff) begin
               num_in   = first_ff ? sum_ff : ((sum_ff > peak_ff) ? sum_ff : peak_ff);
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_ROOT;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            num_in = {num_ff[SQ_WIDTH-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[CW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[CW-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = ST_SEND;
            end else begin
               step_in = step_ff - STEP_WIDTH'(1);
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  rsp_data_in[i*FIELD_WIDTH +: FIELD_WIDTH] = FIELD_WIDTH'(min_ff[i]);
                  rsp_data_in[(AXIS_COUNT+i)*FIELD_WIDTH +: FIELD_WIDTH] =
                     FIELD_WIDTH'(max_ff[i]);
               end
               rsp_data_in[2*AXIS_COUNT*FIELD_WIDTH +: FIELD_WIDTH] = FIELD_WIDTH'(root_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      coord_ff    <= coord_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      product_ff  <= product_in;
      sum_ff      <= sum_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* verif/tb_vertex_bounds_and_radius_core.sv */
module tb_vertex_bounds_and_radius_core;
   import vbr_pkg::*;

   localparam int COORD_WIDTH     = 32;
   localparam int RESULT_LATENCY  = COORD_WIDTH + 7;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 2000;
   localparam int MAX_REPORTS     = 40;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] x;
      logic [FIELD_WIDTH-1:0] y;
      logic [FIELD_WIDTH-1:0] z;
      logic                   first;
      logic                   last;
   } vertex_type;

   // Declared from the top bit down, so min_x sits in the lowest bits as on rsp_tdata.
   typedef struct packed {
      logic        [FIELD_WIDTH-1:0] radius;
      logic signed [FIELD_WIDTH-1:0] max_z;
      logic signed [FIELD_WIDTH-1:0] max_y;
      logic signed [FIELD_WIDTH-1:0] max_x;
      logic signed [FIELD_WIDTH-1:0] min_z;
      logic signed [FIELD_WIDTH-1:0] min_y;
      logic signed [FIELD_WIDTH-1:0] min_x;
   } bounds_type;

   typedef struct {
      vertex_type vertex;
      bit         typed;
      bounds_type box;
   } stimulus_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      req_tuser;
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   logic signed [FIELD_WIDTH-1:0] box_min [3];
   logic signed [FIELD_WIDTH-1:0] box_max [3];
   logic [63:0]                   peak_square_sum;

   stimulus_type queued_vertices [$];
   stimulus_type directed_rows [$];
   bounds_type   pending_boxes [$];

   int send_idle_pct;
   int recv_idle_pct;
   int failures;
   int stalled_cycles;
   bit hold_off_request;
   bit hold_off_done;

   vertex_bounds_and_radius_core #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic signed [FIELD_WIDTH-1:0] coord_value(logic [FIELD_WIDTH-1:0] raw);
      logic signed [FIELD_WIDTH-1:0] shifted;
      shifted = raw << (FIELD_WIDTH - COORD_WIDTH);
      return shifted >>> (FIELD_WIDTH - COORD_WIDTH);
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] floor_root(logic [63:0] value);
      logic [FIELD_WIDTH-1:0] root;
      logic [FIELD_WIDTH-1:0] trial;
      root = '0;
      for (int b = FIELD_WIDTH - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Merges one vertex into the running box and peak square; a last vertex yields a box.
   task automatic merge_vertex(input vertex_type v, output bit done, output bounds_type box);
      logic signed [FIELD_WIDTH-1:0] c [3];
      logic signed [63:0]            wide;
      logic [63:0]                   square_sum;
      c[0] = coord_value(v.x);
      c[1] = coord_value(v.y);
      c[2] = coord_value(v.z);
      square_sum = '0;
      for (int a = 0; a < 3; a++) begin
         wide = 64'(c[a]);
         square_sum += 64'(wide * wide);
      end
      if (v.first) begin
         for (int a = 0; a < 3; a++) begin
            box_min[a] = c[a];
            box_max[a] = c[a];
         end
         peak_square_sum = square_sum;
      end else begin
         for (int a = 0; a < 3; a++) begin
            if (c[a] < box_min[a]) box_min[a] = c[a];
            if (c[a] > box_max[a]) box_max[a] = c[a];
         end
         if (square_sum > peak_square_sum) peak_square_sum = square_sum;
      end
      done = v.last;
      box = {floor_root(peak_square_sum), box_max[2], box_max[1], box_max[0],
             box_min[2], box_min[1], box_min[0]};
   endtask

   task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input bit first, input bit last,
                          input bit typed = 1'b0, input bounds_type box = '0);
      stimulus_type s;
      s.vertex.x     = x;
      s.vertex.y     = y;
      s.vertex.z     = z;
      s.vertex.first = first;
      s.vertex.last  = last;
      s.typed        = typed;
      s.box          = box;
      directed_rows.push_back(s);
   endtask

   task automatic offer_vertex(input stimulus_type s);
      queued_vertices.push_back(s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {s.vertex.z, s.vertex.y, s.vertex.x};
      req_tuser  = s.vertex.first;
      req_tlast  = s.vertex.last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      logic [31:0] value;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               default: value = 32'h0000_0000;
            endcase
         end
         1, 2: value = $urandom_range(0, 4000) - 2000;
         3, 4: value = $urandom_range(0, 200 << 16) - (100 << 16);
         default: value = $urandom();
      endcase
      return value;
   endfunction

   // Mostly whole objects with random content; about one pick in ten is a single vertex with random flags.
   task automatic send_random_objects(input int count);
      int           sent;
      int           length;
      stimulus_type s;
      sent    = 0;
      s.typed = 1'b0;
      s.box   = '0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            s.vertex.x     = random_coord();
            s.vertex.y     = random_coord();
            s.vertex.z     = random_coord();
            s.vertex.first = 1'($urandom_range(0, 1));
            s.vertex.last  = 1'($urandom_range(0, 1));
            offer_vertex(s);
            sent++;
         end else begin
            length = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int k = 0; k < length; k++) begin
               s.vertex.x     = random_coord();
               s.vertex.y     = random_coord();
               s.vertex.z     = random_coord();
               s.vertex.first = (k == 0);
               s.vertex.last  = (k == length - 1);
               offer_vertex(s);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      bounds_type   got;
      bounds_type   want;
      bounds_type   predicted;
      stimulus_type s;
      bit           done;
      string        field_names [7];
      field_names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z", "radius"};
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_boxes.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("%0t: expected no result transaction, got %h", $time, got);
               end
            end else begin
               want = pending_boxes.pop_front();
               for (int i = 0; i < 7; i++) begin
                  if (got[i*FIELD_WIDTH +: FIELD_WIDTH] !==
                      want[i*FIELD_WIDTH +: FIELD_WIDTH]) begin
                     failures++;
                     if (failures <= MAX_REPORTS) begin
                        $display("%0t: %s expected %h, got %h", $time, field_names[i],
                                 want[i*FIELD_WIDTH +: FIELD_WIDTH],
                                 got[i*FIELD_WIDTH +: FIELD_WIDTH]);
                     end
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            s = queued_vertices.pop_front();
            merge_vertex(s.vertex, done, predicted);
            if (done) pending_boxes.push_back(s.typed ? s.box : predicted);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : sender
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      req_tlast        = 1'b0;
      failures         = 0;
      stalled_cycles   = 0;
      hold_off_request = 1'b0;
      hold_off_done    = 1'b0;
      send_idle_pct    = 28;
      recv_idle_pct    = 58;
      for (int a = 0; a < 3; a++) begin
         box_min[a] = '0;
         box_max[a] = '0;
      end
      peak_square_sum = '0;

      // Without a first vertex after reset the box also takes in the origin.
      add_row(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1,
              bounds_type'{radius: 32'h0001_0000, max_z: 0, max_y: 0, max_x: 32'h0001_0000,
                           min_z: 0, min_y: 0, min_x: 0});
      add_row(32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1, bounds_type'('0));
      add_row(32'd3, 32'd4, 32'd0, 1'b1, 1'b1, 1'b1,
              bounds_type'{radius: 5, max_z: 0, max_y: 4, max_x: 3,
                           min_z: 0, min_y: 4, min_x: 3});
      add_row(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1,
              bounds_type'{radius: 32'h7FFF_FFFF, max_z: 0, max_y: 0, max_x: 32'h7FFF_FFFF,
                           min_z: 0, min_y: 0, min_x: 32'h7FFF_FFFF});
      add_row(32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1,
              bounds_type'{radius: 32'h8000_0000, max_z: 0, max_y: 0, max_x: 32'h8000_0000,
                           min_z: 0, min_y: 0, min_x: 32'h8000_0000});
      // No first vertex after a last one continues the previous object.
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 1'b1, 1'b0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFB, 1'b0, 1'b0);
      add_row(32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_row(32'h0, 32'h0, 32'h8000_0000, 1'b0, 1'b0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
      // Equal coordinates leave the bounds as they are.
      add_row(32'h0007_0000, 32'h0007_0000, 32'h0007_0000, 1'b1, 1'b0);
      add_row(32'h0007_0000, 32'h0007_0000, 32'h0007_0000, 1'b0, 1'b1);
      // A second first vertex restarts an object that never saw its last vertex.
      add_row(32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 1'b1, 1'b0);
      add_row(32'd1, 32'd2, 32'd3, 1'b1, 1'b0);
      add_row(32'hFFFF_0000, 32'd2, 32'd3, 1'b0, 1'b0);
      add_row(32'd5, 32'd5, 32'd5, 1'b0, 1'b0);
      add_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
      add_row(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b1, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) offer_vertex(directed_rows[i]);
      send_random_objects(RANDOM_ITEMS / 3);

      send_idle_pct = 58;
      recv_idle_pct = 28;
      send_random_objects(RANDOM_ITEMS / 3);

      // The receiver holds off for a long stretch while vertices keep coming.
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = 1'b1;
      send_random_objects(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid = 1'b0;

      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 10) @(posedge clock);
      if (failures == 0 && pending_boxes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
